FILE: rtl/core/btpm_pkg.sv
`default_nettype none

package btpm_pkg;

  localparam int unsigned ADDR_W   = 128;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned POP_W    = 16;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned NODE_COUNT_DEF   = 4096;
  localparam int unsigned ADDRESS_BITS_DEF = 128;
  localparam int unsigned TAG_BITS_DEF     = 16;

  // Entries of the queue between front end and trie engine
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FOUND     = 3'd1,
    ST_NO_MATCH  = 3'd2,
    ST_DUPLICATE = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ES_IDLE,
    ES_STEP,
    ES_DONE
  } eng_state_e;

  typedef struct packed {
    logic               cmd;
    logic [HALF_W-1:0]  address_high;
    logic [HALF_W-1:0]  address_low;
    logic [LEN_W-1:0]   pfx_len;
    logic [POP_W-1:0]   route_pop;
  } in_t;

  typedef struct packed {
    status_e            status;
    logic [POP_W-1:0]   match_pop;
    logic [LEN_W-1:0]   match_length;
  } out_t;

  // Classified request as queued for the engine
  typedef struct packed {
    op_e                op;
    logic [ADDR_W-1:0]  address;
    logic [LEN_W-1:0]   length;
    logic [POP_W-1:0]   pop;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/core/btpm_front.sv
`default_nettype none

module btpm_front #(
  parameter int unsigned ADDRESS_BITS = btpm_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  input  wire btpm_pkg::in_t   in_i,
  output logic                 push_valid_o,
  input  wire logic            push_stall_i,
  output btpm_pkg::item_t      push_item_o
);

  logic            valid_q, valid_d;
  btpm_pkg::item_t item_q, item_d;
  logic            take;

  assign in_stall_o   = valid_q && push_stall_i;
  assign take         = in_valid_i && !in_stall_o;
  assign push_valid_o = valid_q;
  assign push_item_o  = item_q;

  always_comb begin
    item_d         = item_q;
    item_d.address = {in_i.address_high, in_i.address_low};
    item_d.pop     = in_i.route_pop;
    // lengths beyond the address width saturate
    if (in_i.pfx_len > btpm_pkg::LEN_W'(ADDRESS_BITS)) begin
      item_d.length = btpm_pkg::LEN_W'(ADDRESS_BITS);
    end else begin
      item_d.length = in_i.pfx_len;
    end
    unique case (in_i.cmd)
      1'b0:    item_d.op = btpm_pkg::OP_INSERT;
      default: item_d.op = btpm_pkg::OP_LOOKUP;
    endcase
    valid_d = take || (valid_q && push_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/btpm_queue.sv
`default_nettype none

module btpm_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_stall_o,
  input  wire btpm_pkg::item_t push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_stall_i,
  output btpm_pkg::item_t      pop_item_o
);

  localparam int unsigned Depth = btpm_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  btpm_pkg::item_t  slots_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             push, pop;

  assign push_stall_o = (count_q == CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_valid_o && !pop_stall_i;
  assign pop_item_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/btpm_engine.sv
`default_nettype none

module btpm_engine #(
  parameter int unsigned NODE_COUNT = btpm_pkg::NODE_COUNT_DEF,
  parameter int unsigned TAG_BITS   = btpm_pkg::TAG_BITS_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            pop_valid_i,
  output logic                 pop_stall_o,
  input  wire btpm_pkg::item_t pop_item_i,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  output btpm_pkg::out_t       out_o
);

  localparam int unsigned IdxW = $clog2(NODE_COUNT);
  localparam int unsigned CntW = $clog2(NODE_COUNT + 1);
  localparam int unsigned AddrW = btpm_pkg::ADDR_W;
  localparam int unsigned LenW  = btpm_pkg::LEN_W;
  localparam int unsigned PopW  = btpm_pkg::POP_W;

  typedef struct packed {
    logic [IdxW-1:0]     child0;
    logic [IdxW-1:0]     child1;
    logic                has_tag;
    logic [TAG_BITS-1:0] tag;
  } node_t;

  // Node pool; entry 0 (the root) lives in flops, others are written on allocation
  node_t node_mem [NODE_COUNT];

  btpm_pkg::eng_state_e state_q, state_d;
  btpm_pkg::op_e        op_q, op_d;
  logic [AddrW-1:0]     addr_q, addr_d;
  logic [LenW-1:0]      len_q, len_d;
  logic [TAG_BITS-1:0]  tag_q, tag_d;
  logic [IdxW-1:0]      cur_q, cur_d;
  logic [LenW-1:0]      depth_q, depth_d;
  logic                 fresh_q, fresh_d;
  logic                 found_q, found_d;
  logic [TAG_BITS-1:0]  fpop_q, fpop_d;
  logic [LenW-1:0]      flen_q, flen_d;
  logic [CntW-1:0]      used_q, used_d;
  node_t                root_q, root_d;
  node_t                rd_q;
  btpm_pkg::out_t       res_q, res_d;
  btpm_pkg::out_t       out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic                 mem_we, mem_re;
  logic [IdxW-1:0]      mem_waddr, mem_raddr;
  node_t                mem_wdata;

  node_t                node, upd;
  logic                 bit_b, walking, check, out_free;
  logic [IdxW-1:0]      child_b, next_fb, new_idx;

  assign pop_stall_o = (state_q != btpm_pkg::ES_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  always_comb begin
    if (cur_q == '0) begin
      node = root_q;
    end else if (fresh_q) begin
      node = '0;
    end else begin
      node = rd_q;
    end
    bit_b   = addr_q[AddrW-1];
    child_b = bit_b ? node.child1 : node.child0;
    next_fb = (node.child0 != '0) ? node.child0 : node.child1;
    walking = (depth_q < len_q);
    // root tag only counts for a zero-length query
    check   = node.has_tag && !(depth_q == '0 && len_q != '0);
    new_idx = used_q[IdxW-1:0];
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    addr_d      = addr_q;
    len_d       = len_q;
    tag_d       = tag_q;
    cur_d       = cur_q;
    depth_d     = depth_q;
    fresh_d     = fresh_q;
    found_d     = found_q;
    fpop_d      = fpop_q;
    flen_d      = flen_q;
    used_d      = used_q;
    root_d      = root_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_waddr   = cur_q;
    mem_raddr   = child_b;
    mem_wdata   = node;
    upd         = node;

    unique case (state_q)
      btpm_pkg::ES_IDLE: begin
        if (pop_valid_i) begin
          op_d    = pop_item_i.op;
          addr_d  = pop_item_i.address;
          len_d   = pop_item_i.length;
          tag_d   = TAG_BITS'(pop_item_i.pop);
          cur_d   = '0;
          depth_d = '0;
          fresh_d = 1'b0;
          found_d = 1'b0;
          state_d = btpm_pkg::ES_STEP;
        end
      end

      btpm_pkg::ES_STEP: begin
        if (op_q == btpm_pkg::OP_INSERT) begin
          if (walking) begin
            if (child_b != '0) begin
              mem_re  = 1'b1;
              cur_d   = child_b;
              fresh_d = 1'b0;
              depth_d = depth_q + LenW'(1);
              addr_d  = addr_q << 1;
            end else if (used_q == CntW'(NODE_COUNT)) begin
              // flush the node we stand on so a fresh one is not left unwritten
              mem_we       = (cur_q != '0);
              res_d.status = btpm_pkg::ST_FULL;
              res_d.match_pop    = '0;
              res_d.match_length = '0;
              state_d      = btpm_pkg::ES_DONE;
            end else begin
              if (bit_b) begin
                upd.child1 = new_idx;
              end else begin
                upd.child0 = new_idx;
              end
              if (cur_q == '0) begin
                root_d = upd;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = upd;
              end
              used_d  = used_q + CntW'(1);
              cur_d   = new_idx;
              fresh_d = 1'b1;
              depth_d = depth_q + LenW'(1);
              addr_d  = addr_q << 1;
            end
          end else begin
            res_d.match_pop    = '0;
            res_d.match_length = '0;
            state_d            = btpm_pkg::ES_DONE;
            if (node.has_tag) begin
              res_d.status = btpm_pkg::ST_DUPLICATE;
            end else begin
              upd.has_tag  = 1'b1;
              upd.tag      = tag_q;
              res_d.status = btpm_pkg::ST_INSERTED;
              if (cur_q == '0) begin
                root_d = upd;
              end else begin
                mem_we    = 1'b1;
                mem_wdata = upd;
              end
            end
          end
        end else begin
          if (walking) begin
            if (check) begin
              found_d = 1'b1;
              fpop_d  = node.tag;
              flen_d  = depth_q;
            end
            if (child_b == '0) begin
              state_d = btpm_pkg::ES_DONE;
              if (check || found_q) begin
                res_d.status       = btpm_pkg::ST_FOUND;
                res_d.match_pop    = check ? PopW'(node.tag) : PopW'(fpop_q);
                res_d.match_length = check ? depth_q : flen_q;
              end else begin
                res_d.status       = btpm_pkg::ST_NO_MATCH;
                res_d.match_pop    = '0;
                res_d.match_length = '0;
              end
            end else begin
              mem_re  = 1'b1;
              cur_d   = child_b;
              fresh_d = 1'b0;
              depth_d = depth_q + LenW'(1);
              addr_d  = addr_q << 1;
            end
          end else begin
            // end of query prefix: report deepest match or descend to first tag
            if (check || found_q) begin
              state_d            = btpm_pkg::ES_DONE;
              res_d.status       = btpm_pkg::ST_FOUND;
              res_d.match_pop    = check ? PopW'(node.tag) : PopW'(fpop_q);
              res_d.match_length = check ? depth_q : flen_q;
            end else if (next_fb == '0) begin
              state_d            = btpm_pkg::ES_DONE;
              res_d.status       = btpm_pkg::ST_NO_MATCH;
              res_d.match_pop    = '0;
              res_d.match_length = '0;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = next_fb;
              cur_d     = next_fb;
              fresh_d   = 1'b0;
              depth_d   = depth_q + LenW'(1);
            end
          end
        end
      end

      btpm_pkg::ES_DONE: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = btpm_pkg::ES_IDLE;
        end
      end

      default: begin
        state_d = btpm_pkg::ES_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= btpm_pkg::ES_IDLE;
      used_q      <= CntW'(1);
      root_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      root_q      <= root_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    addr_q  <= addr_d;
    len_q   <= len_d;
    tag_q   <= tag_d;
    cur_q   <= cur_d;
    depth_q <= depth_d;
    fresh_q <= fresh_d;
    found_q <= found_d;
    fpop_q  <= fpop_d;
    flen_q  <= flen_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= node_mem[mem_raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ipv6_binary_trie_prefix_match.sv
// Binary trie longest-prefix match over IPv6 routes.
// Input channel (in_valid_i / in_stall_o / in_i): one transaction per request,
// cmd 0 inserts address and prefix length (pfx_len) with tag route_pop,
// cmd 1 looks up.
// Output channel (out_valid_o / out_stall_i / out_o): exactly one result per
// request, in order: status, match_pop, match_length.
// A front stage saturates the length and decodes the command, a two-entry
// queue feeds the trie engine, which holds the root in flops and the other nodes in one memory.
// The engine reads one node per cycle while it walks, on an insert and on a
// lookup (walk plus fallback descent), and holds one item at a time: it takes
// no new item until its result has moved to the output register.
// A request passes the front register, the queue, the engine's walk and its
// output register before its result shows on out_valid_o.
// The front keeps accepting until the queue fills.
// Reset empties the pool to the root alone (used_q = 1); no clearing pass
// is needed since pool entries are written when allocated.
// A stalled result waits in the output register; the engine then holds its
// next result, and the queue and front fill and raise in_stall_o.
`default_nettype none

module ipv6_binary_trie_prefix_match #(
  parameter int unsigned NODE_COUNT   = btpm_pkg::NODE_COUNT_DEF,
  parameter int unsigned ADDRESS_BITS = btpm_pkg::ADDRESS_BITS_DEF,
  parameter int unsigned TAG_BITS     = btpm_pkg::TAG_BITS_DEF
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire btpm_pkg::in_t  in_i,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output btpm_pkg::out_t      out_o
);

  logic            push_valid, push_stall;
  btpm_pkg::item_t push_item;
  logic            pop_valid, pop_stall;
  btpm_pkg::item_t pop_item;

  btpm_front #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_stall_i (push_stall),
    .push_item_o  (push_item)
  );

  btpm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_stall_i  (pop_stall),
    .pop_item_o   (pop_item)
  );

  btpm_engine #(
    .NODE_COUNT (NODE_COUNT),
    .TAG_BITS   (TAG_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_stall_o (pop_stall),
    .pop_item_i  (pop_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_o)
  );

  a_non_found_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.status != btpm_pkg::ST_FOUND) |->
      (out_o.match_pop == '0 && out_o.match_length == '0))
    else $error("non-found result carries match data");

  a_match_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_o.match_length <= btpm_pkg::LEN_W'(ADDRESS_BITS)))
    else $error("match depth beyond address width");

  a_length_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid |-> (push_item.length <= btpm_pkg::LEN_W'(ADDRESS_BITS)))
    else $error("queued prefix length not saturated");

  a_engine_takes_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && !pop_stall) |=> pop_stall)
    else $error("engine accepted a second request while busy");

endmodule

`default_nettype wire
